[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion helpers for the byte pixel decoder
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on an explicit clock and active-low reset
`define ASSERT_CLK(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) else $error(msg);

// concurrent check on the block clock and reset
`define VBPD_ASSERT(lbl, prop, msg) \
	`ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

[sv/vbpd_pkg.sv]
// ----------------------------------------------------------------------------
// vbpd_pkg
// Shared types, color codes, palette and font table of the byte pixel decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package vbpd_pkg;

	// register indexes of the configuration port
	localparam logic [2:0] REG_GRAPHICS_SELECT     = 3'd0;
	localparam logic [2:0] REG_GRAPHICS_MODE       = 3'd1;
	localparam logic [2:0] REG_COLOR_SET           = 3'd2;
	localparam logic [2:0] REG_SEMIGRAPHICS_SELECT = 3'd3;
	localparam logic [2:0] REG_SIX_BLOCK_SELECT    = 3'd4;
	localparam logic [2:0] REG_INVERT_TEXT         = 3'd5;

	localparam int unsigned CFG_WIDTH = 3;

	// default depth of the descriptor queue
	localparam int unsigned VBPD_QUEUE_DEPTH = 2;

	// line / 12 as (line * 171) >> 11, exact for 8-bit lines
	localparam logic [15:0] ROW_RECIP = 16'd171;
	localparam int unsigned ROW_SHIFT = 11;
	localparam logic [7:0]  ROWS_PER_CELL = 8'd12;

	// font rows that carry glyph data
	localparam logic [3:0] GLYPH_FIRST_ROW = 4'd3;
	localparam logic [3:0] GLYPH_LAST_ROW  = 4'd9;

	// last pixel counter value for single and doubled units
	localparam logic [3:0] LAST_SINGLE = 4'd7;
	localparam logic [3:0] LAST_DOUBLE = 4'd15;

	// color codes: 0..7 are the palette, then the fixed colors
	localparam logic [3:0] CODE_GREEN       = 4'd0;
	localparam logic [3:0] CODE_BUFF        = 4'd4;
	localparam logic [3:0] CODE_ORANGE      = 4'd7;
	localparam logic [3:0] CODE_BLACK       = 4'd8;
	localparam logic [3:0] CODE_DARK_GREEN  = 4'd9;
	localparam logic [3:0] CODE_DARK_ORANGE = 4'd10;

	typedef struct packed {
		logic [7:0] line;
		logic [7:0] video_byte;
	} vbpd_in_t;

	typedef struct packed {
		logic [23:0] pixel_rgb;
		logic        last_pixel;
	} vbpd_out_t;

	typedef struct packed {
		logic       graphics_select;
		logic [2:0] graphics_mode;
		logic       color_set;
		logic       semigraphics_select;
		logic       six_block_select;
		logic       invert_text;
	} vbpd_cfg_t;

	// one decoded byte: eight color units, left first, optionally doubled
	typedef struct packed {
		logic            dbl;
		logic [7:0][3:0] codes;
	} vbpd_desc_t;

	typedef struct packed {
		logic       valid;
		vbpd_desc_t desc;
	} vbpd_push_t;

	typedef struct packed {
		logic empty;
		logic full;
	} vbpd_qstat_t;

	typedef struct packed {
		logic busy;
	} vbpd_bstat_t;

	// color code to packed rgb, red in the low byte
	function automatic logic [23:0] code_rgb(input logic [3:0] code);
		logic [23:0] rgb;
		unique case (code)
			4'd0:             rgb = 24'h0EC219;
			4'd1:             rgb = 24'h0DC8CE;
			4'd2:             rgb = 24'hE91D02;
			4'd3:             rgb = 24'h091DCE;
			4'd4:             rgb = 24'hCDC8BC;
			4'd5:             rgb = 24'hCEBE14;
			4'd6:             rgb = 24'hCE34B9;
			4'd7:             rgb = 24'h0E29BA;
			CODE_DARK_GREEN:  rgb = 24'h002400;
			CODE_DARK_ORANGE: rgb = 24'h000E22;
			default:          rgb = 24'h111111;
		endcase
		return rgb;
	endfunction

	// font rows 3..9 of a glyph, row 3 in the top byte
	function automatic logic [6:0][7:0] glyph_word(input logic [5:0] idx);
		logic [55:0] w;
		unique case (idx)
			6'd0:  w = 56'h1C22021A2A2A1C;
			6'd1:  w = 56'h081422223E2222;
			6'd2:  w = 56'h3C12121C12123C;
			6'd3:  w = 56'h1C22202020221C;
			6'd4:  w = 56'h3C12121212123C;
			6'd5:  w = 56'h3E20203820203E;
			6'd6:  w = 56'h3E202038202020;
			6'd7:  w = 56'h1E20202622221E;
			6'd8:  w = 56'h2222223E222222;
			6'd9:  w = 56'h1C08080808081C;
			6'd10: w = 56'h0202020222221C;
			6'd11: w = 56'h22242830282422;
			6'd12: w = 56'h2020202020203E;
			6'd13: w = 56'h22362A2A222222;
			6'd14: w = 56'h22322A26222222;
			6'd15: w = 56'h3E22222222223E;
			6'd16: w = 56'h3C22223C202020;
			6'd17: w = 56'h1C2222222A241A;
			6'd18: w = 56'h3C22223C282422;
			6'd19: w = 56'h1C22100804221C;
			6'd20: w = 56'h3E080808080808;
			6'd21: w = 56'h2222222222221C;
			6'd22: w = 56'h22222214140808;
			6'd23: w = 56'h2222222A2A3622;
			6'd24: w = 56'h22221408142222;
			6'd25: w = 56'h22221408080808;
			6'd26: w = 56'h3E02040810203E;
			6'd27: w = 56'h38202020202038;
			6'd28: w = 56'h20201008040202;
			6'd29: w = 56'h0E02020202020E;
			6'd30: w = 56'h081C2A08080808;
			6'd31: w = 56'h0008103E100800;
			6'd32: w = 56'h00000000000000;
			6'd33: w = 56'h08080808080008;
			6'd34: w = 56'h14141400000000;
			6'd35: w = 56'h14143600361414;
			6'd36: w = 56'h081E201C023C08;
			6'd37: w = 56'h32320408102626;
			6'd38: w = 56'h102828102A241A;
			6'd39: w = 56'h18181800000000;
			6'd40: w = 56'h08102020201008;
			6'd41: w = 56'h08040202020408;
			6'd42: w = 56'h00081C3E1C0800;
			6'd43: w = 56'h0008083E080800;
			6'd44: w = 56'h00000030301020;
			6'd45: w = 56'h0000003E000000;
			6'd46: w = 56'h00000000003030;
			6'd47: w = 56'h02020408102020;
			6'd48: w = 56'h18242424242418;
			6'd49: w = 56'h0818080808081C;
			6'd50: w = 56'h1C22021C20203E;
			6'd51: w = 56'h1C22020402221C;
			6'd52: w = 56'h040C143E040404;
			6'd53: w = 56'h3E203C0202221C;
			6'd54: w = 56'h1C20203C22221C;
			6'd55: w = 56'h3E020408102020;
			6'd56: w = 56'h1C22221C22221C;
			6'd57: w = 56'h1C22221E02021C;
			6'd58: w = 56'h00181800181800;
			6'd59: w = 56'h18180018180810;
			6'd60: w = 56'h04081020100804;
			6'd61: w = 56'h00003E003E0000;
			6'd62: w = 56'h10080402040810;
			6'd63: w = 56'h18240408080008;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

[sv/vbpd_front.sv]
// ----------------------------------------------------------------------------
// vbpd_front
// Accepts a byte and its line, finds the cell row and classifies the byte
// into eight color units for the pixel back end.
// ----------------------------------------------------------------------------
`default_nettype none

module vbpd_front import vbpd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire vbpd_in_t    in_data,
	input  wire vbpd_cfg_t   cfg,
	input  wire vbpd_qstat_t q_stat,
	output vbpd_push_t       push
);

	logic        valid_s1;
	logic [7:0]  line_s1;
	logic [7:0]  byte_s1;
	logic [4:0]  quot_s1;
	logic [15:0] recip_prod;
	logic        take;

	// front holds one transaction until the queue has room
	assign in_stall = valid_s1 && q_stat.full;
	assign take     = in_valid && !in_stall;

	// quotient of line by twelve
	assign recip_prod = {8'd0, in_data.line} * ROW_RECIP;

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (!q_stat.full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			line_s1 <= in_data.line;
			byte_s1 <= in_data.video_byte;
			quot_s1 <= recip_prod[ROW_SHIFT +: 5];
		end
	end

	// cell row from the registered quotient
	logic [7:0] rem_full;
	logic [3:0] row;
	assign rem_full = line_s1 - ({3'd0, quot_s1} * ROWS_PER_CELL);
	assign row      = rem_full[3:0];

	// font row for text mode
	logic [6:0][7:0] glyph;
	logic [3:0]      grow_full;
	logic [2:0]      grow;
	logic            in_glyph;
	logic [7:0]      font_bits;
	assign glyph     = glyph_word(byte_s1[5:0]);
	assign grow_full = row - GLYPH_FIRST_ROW;
	assign grow      = grow_full[2:0];
	assign in_glyph  = (row >= GLYPH_FIRST_ROW) && (row <= GLYPH_LAST_ROW);
	assign font_bits = (in_glyph ? glyph[3'd6 - grow] : 8'd0) ^ {8{cfg.invert_text}};

	// semigraphics block bits for this row
	logic [1:0] blk_bits;
	logic [3:0] blk_fg;
	always_comb begin
		if (cfg.six_block_select) begin
			blk_fg = {cfg.color_set, byte_s1[7:6]};
			unique case (row[3:2])
				2'd0:    blk_bits = byte_s1[5:4];
				2'd1:    blk_bits = byte_s1[3:2];
				default: blk_bits = byte_s1[1:0];
			endcase
		end else begin
			blk_fg   = {1'b0, byte_s1[6:4]};
			blk_bits = (row >= 4'd6) ? byte_s1[1:0] : byte_s1[3:2];
		end
	end

	// classify into eight units, unit 0 leftmost
	vbpd_desc_t desc;
	always_comb begin
		desc = '0;
		for (int i = 0; i < 8; i++) begin
			if (cfg.graphics_select) begin
				if (cfg.graphics_mode[0]) begin
					desc.codes[i] = byte_s1[7 - i] ?
						(cfg.color_set ? CODE_BUFF : CODE_GREEN) : CODE_BLACK;
				end else begin
					desc.codes[i] = {1'b0, cfg.color_set, byte_s1[7 - 2 * (i / 2) -: 2]};
				end
			end else if (cfg.semigraphics_select) begin
				desc.codes[i] = blk_bits[(i < 4) ? 1 : 0] ? blk_fg : CODE_BLACK;
			end else begin
				desc.codes[i] = font_bits[7 - i] ?
					(cfg.color_set ? CODE_ORANGE : CODE_GREEN) :
					(cfg.color_set ? CODE_DARK_ORANGE : CODE_DARK_GREEN);
			end
		end
		// sixteen-pixel runs double every unit
		if (cfg.graphics_select) begin
			if (cfg.graphics_mode[0]) begin
				desc.dbl = !(cfg.graphics_mode[2] && cfg.graphics_mode[1]);
			end else begin
				desc.dbl = (cfg.graphics_mode[2:1] == 2'd0);
			end
		end
	end

	assign push.valid = valid_s1;
	assign push.desc  = desc;

endmodule

`default_nettype wire

[sv/vbpd_queue.sv]
// ----------------------------------------------------------------------------
// vbpd_queue
// Short descriptor queue between the classifying front and the pixel back end.
// ----------------------------------------------------------------------------
`default_nettype none

module vbpd_queue import vbpd_pkg::*; #(
	parameter int unsigned DEPTH = VBPD_QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire vbpd_push_t push,
	input  wire logic       pop,
	output vbpd_desc_t      pop_data,
	output vbpd_qstat_t     q_stat
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	vbpd_desc_t    entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign q_stat.empty = (count_q == '0);
	assign q_stat.full  = (count_q == CW'(DEPTH));
	assign do_push      = push.valid && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign pop_data     = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.desc;
		end
	end

endmodule

`default_nettype wire

[sv/vbpd_back.sv]
// ----------------------------------------------------------------------------
// vbpd_back
// Walks one descriptor a pixel per unstalled cycle into the registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module vbpd_back import vbpd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire vbpd_qstat_t q_stat,
	input  wire vbpd_desc_t  pop_data,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_stall,
	output vbpd_out_t        out_data,
	output vbpd_bstat_t      b_stat
);

	vbpd_desc_t desc_q;
	logic       busy_q;
	logic [3:0] cnt_q;
	logic       out_valid_q;
	vbpd_out_t  out_data_q;

	logic       adv;
	logic       last;
	logic       fin;
	logic [2:0] unit;

	// one pixel per cycle while the output register can take it
	assign adv  = busy_q && (!out_valid_q || !out_stall);
	assign last = desc_q.dbl ? (cnt_q == LAST_DOUBLE) : (cnt_q == LAST_SINGLE);
	assign fin  = adv && last;
	assign unit = desc_q.dbl ? cnt_q[3:1] : cnt_q[2:0];
	assign pop  = (!busy_q || fin) && !q_stat.empty;

	// descriptor and pixel counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (fin) begin
			busy_q <= 1'b0;
		end else if (adv) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			desc_q <= pop_data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q.pixel_rgb  <= code_rgb(desc_q.codes[unit]);
			out_data_q.last_pixel <= last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_data    = out_data_q;
	assign b_stat.busy = busy_q;

endmodule

`default_nettype wire

[sv/video_byte_pixel_decoder_unit.sv]
// ----------------------------------------------------------------------------
// video_byte_pixel_decoder_unit
// Turns one video-memory byte into a run of 8 or 16 RGB pixels.
// ----------------------------------------------------------------------------
// The back end emits one pixel per cycle from its pixel counter unless the
// output stalls; the next byte's pixels follow with no gap when its
// descriptor is already queued. An accepted byte passes the stage 1 register,
// the queue write, the descriptor load in the back end and the output
// register before its first pixel appears. Bytes keep being taken while the
// back end is busy until the queue is full and the front holds a byte too.
// The user must write mode registers through cfg_we/cfg_index/cfg_wdata only
// while the block is idle; the block itself does not enforce this.
`default_nettype none

`include "assert_macros.svh"

module video_byte_pixel_decoder_unit import vbpd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = VBPD_QUEUE_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire vbpd_in_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output vbpd_out_t                 out_data,
	input  wire logic                 cfg_we,
	input  wire logic [2:0]           cfg_index,
	input  wire logic [CFG_WIDTH-1:0] cfg_wdata
);

	vbpd_cfg_t   cfg_q;
	vbpd_push_t  push;
	vbpd_qstat_t q_stat;
	vbpd_desc_t  pop_data;
	vbpd_bstat_t b_stat;
	logic        pop;

	// mode registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRAPHICS_SELECT:     cfg_q.graphics_select     <= cfg_wdata[0];
				REG_GRAPHICS_MODE:       cfg_q.graphics_mode       <= cfg_wdata[2:0];
				REG_COLOR_SET:           cfg_q.color_set           <= cfg_wdata[0];
				REG_SEMIGRAPHICS_SELECT: cfg_q.semigraphics_select <= cfg_wdata[0];
				REG_SIX_BLOCK_SELECT:    cfg_q.six_block_select    <= cfg_wdata[0];
				REG_INVERT_TEXT:         cfg_q.invert_text         <= cfg_wdata[0];
				default:                 cfg_q                     <= cfg_q;
			endcase
		end
	end

	vbpd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.cfg      (cfg_q),
		.q_stat   (q_stat),
		.push     (push)
	);

	vbpd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop      (pop),
		.pop_data (pop_data),
		.q_stat   (q_stat)
	);

	vbpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.b_stat    (b_stat)
	);

	// queue never reports empty and full together
	`VBPD_ASSERT(a_queue_flags, !(q_stat.empty && q_stat.full), "queue empty and full at once")
	// back end only pops a filled queue
	`VBPD_ASSERT(a_pop_nonempty, pop |-> !q_stat.empty, "pop from empty queue")
	// a pixel that is not the last leaves while its byte is still being walked
	`VBPD_ASSERT(a_busy_mid_run, out_valid && !out_stall && !out_data.last_pixel |-> b_stat.busy,
		"non-last pixel taken with back end idle")

endmodule

`default_nettype wire

[bench/tb_video_byte_pixel_decoder_unit.sv]
// ----------------------------------------------------------------------------
// tb_video_byte_pixel_decoder_unit
// Self-checking bench for the byte pixel decoder. Sends video bytes with
// their line numbers under many mode settings. Builds the expected pixel runs
// with its own decoder and compares every pixel as it leaves the block. The
// input idles and the output stalls at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_video_byte_pixel_decoder_unit;
	import vbpd_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 6;
	localparam int TAIL_CYCLES  = 8;
	localparam int MAX_REPORTS  = 10;

	// indexes outside the register map, writes must be ignored
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	localparam logic [23:0] RGB_BLACK       = 24'h111111;
	localparam logic [23:0] RGB_DARK_GREEN  = 24'h002400;
	localparam logic [23:0] RGB_DARK_ORANGE = 24'h000E22;

	localparam logic [23:0] PALETTE_RGB [8] = '{
		24'h0EC219, 24'h0DC8CE, 24'hE91D02, 24'h091DCE,
		24'hCDC8BC, 24'hCEBE14, 24'hCE34B9, 24'h0E29BA
	};

	// glyph rows 3..9, row 3 in the top byte
	localparam logic [55:0] FONT_ROWS [64] = '{
		56'h1C22021A2A2A1C, 56'h081422223E2222, 56'h3C12121C12123C, 56'h1C22202020221C,
		56'h3C12121212123C, 56'h3E20203820203E, 56'h3E202038202020, 56'h1E20202622221E,
		56'h2222223E222222, 56'h1C08080808081C, 56'h0202020222221C, 56'h22242830282422,
		56'h2020202020203E, 56'h22362A2A222222, 56'h22322A26222222, 56'h3E22222222223E,
		56'h3C22223C202020, 56'h1C2222222A241A, 56'h3C22223C282422, 56'h1C22100804221C,
		56'h3E080808080808, 56'h2222222222221C, 56'h22222214140808, 56'h2222222A2A3622,
		56'h22221408142222, 56'h22221408080808, 56'h3E02040810203E, 56'h38202020202038,
		56'h20201008040202, 56'h0E02020202020E, 56'h081C2A08080808, 56'h0008103E100800,
		56'h00000000000000, 56'h08080808080008, 56'h14141400000000, 56'h14143600361414,
		56'h081E201C023C08, 56'h32320408102626, 56'h102828102A241A, 56'h18181800000000,
		56'h08102020201008, 56'h08040202020408, 56'h00081C3E1C0800, 56'h0008083E080800,
		56'h00000030301020, 56'h0000003E000000, 56'h00000000003030, 56'h02020408102020,
		56'h18242424242418, 56'h0818080808081C, 56'h1C22021C20203E, 56'h1C22020402221C,
		56'h040C143E040404, 56'h3E203C0202221C, 56'h1C20203C22221C, 56'h3E020408102020,
		56'h1C22221C22221C, 56'h1C22221E02021C, 56'h00181800181800, 56'h18180018180810,
		56'h04081020100804, 56'h00003E003E0000, 56'h10080402040810, 56'h18240408080008
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid;
	logic in_stall;
	vbpd_in_t in_data;
	logic out_valid;
	logic out_stall = 1'b0;
	vbpd_out_t out_data;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [CFG_WIDTH-1:0] cfg_wdata;

	vbpd_cfg_t mode_regs;
	vbpd_out_t pixel_q[$];
	int mismatches = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;

	video_byte_pixel_decoder_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// clock, 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run length guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_video_byte_pixel_decoder_unit: FAIL");
			$finish;
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic note_mismatch(input string what, input logic [23:0] want,
			input logic [23:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch %s at cycle %0d: expected %06h got %06h",
				what, cycles, want, got);
	endtask

	// expected pixel run of one byte under the current modes
	function automatic void predict_pixels(input vbpd_in_t item);
		logic [23:0] px [16];
		logic [23:0] fg;
		logic [23:0] bg;
		logic [23:0] color;
		logic [7:0] b;
		logic [7:0] glyph;
		logic [1:0] blocks;
		vbpd_out_t pix;
		int n;
		int row;
		int dots;
		int sh;
		n = 0;
		b = item.video_byte;
		row = int'(item.line) % 12;
		if (mode_regs.graphics_select) begin
			if (mode_regs.graphics_mode[0]) begin
				// resolution graphics, one bit per unit
				dots = (mode_regs.graphics_mode[2:1] == 2'd3) ? 1 : 2;
				fg = mode_regs.color_set ? PALETTE_RGB[4] : PALETTE_RGB[0];
				for (int p = 7; p >= 0; p--) begin
					color = b[p] ? fg : RGB_BLACK;
					repeat (dots) begin
						px[n] = color;
						n++;
					end
				end
			end else begin
				// color graphics, two bits per unit
				dots = (mode_regs.graphics_mode[2:1] == 2'd0) ? 4 : 2;
				for (int p = 3; p >= 0; p--) begin
					color = PALETTE_RGB[{mode_regs.color_set, b[p*2 +: 2]}];
					repeat (dots) begin
						px[n] = color;
						n++;
					end
				end
			end
		end else if (mode_regs.semigraphics_select) begin
			if (mode_regs.six_block_select) begin
				sh = (2 - row / 4) * 2;
				fg = PALETTE_RGB[{mode_regs.color_set, b[7:6]}];
			end else begin
				sh = (1 - row / 6) * 2;
				fg = PALETTE_RGB[b[6:4]];
			end
			blocks = b[sh +: 2];
			for (int k = 1; k >= 0; k--) begin
				color = blocks[k] ? fg : RGB_BLACK;
				repeat (4) begin
					px[n] = color;
					n++;
				end
			end
		end else begin
			// text from the internal font, blank above and below the glyph
			fg = mode_regs.color_set ? PALETTE_RGB[7] : PALETTE_RGB[0];
			bg = mode_regs.color_set ? RGB_DARK_ORANGE : RGB_DARK_GREEN;
			glyph = 8'h00;
			if (row >= 3 && row <= 9)
				glyph = FONT_ROWS[b[5:0]][(9 - row) * 8 +: 8];
			if (mode_regs.invert_text)
				glyph = ~glyph;
			for (int p = 7; p >= 0; p--) begin
				px[n] = glyph[p] ? fg : bg;
				n++;
			end
		end
		for (int i = 0; i < n; i++) begin
			pix.pixel_rgb = px[i];
			pix.last_pixel = (i == n - 1);
			pixel_q.push_back(pix);
		end
	endfunction

	// compare each accepted pixel against the oldest expectation
	always @(posedge clk) begin : check_pixels
		vbpd_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pixel_q.size() == 0) begin
				note_mismatch("unexpected pixel", 24'h0, out_data.pixel_rgb);
			end else begin
				want = pixel_q.pop_front();
				if (out_data.pixel_rgb !== want.pixel_rgb)
					note_mismatch("pixel_rgb", want.pixel_rgb, out_data.pixel_rgb);
				if (out_data.last_pixel !== want.last_pixel)
					note_mismatch("last_pixel", {23'h0, want.last_pixel},
						{23'h0, out_data.last_pixel});
			end
		end
	end

	// one byte transaction, with random idle cycles in front
	task automatic send_byte(input logic [7:0] line_no, input logic [7:0] value);
		vbpd_in_t item;
		item.line = line_no;
		item.video_byte = value;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_pixels(item);
	endtask

	// stop sending and let every expected pixel come out
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pixel_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [CFG_WIDTH-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	// program all mode registers while the block is idle
	task automatic load_modes(input vbpd_cfg_t modes);
		wait_idle();
		write_reg(REG_GRAPHICS_SELECT, CFG_WIDTH'(modes.graphics_select));
		write_reg(REG_GRAPHICS_MODE, modes.graphics_mode);
		write_reg(REG_SPARE_LO, CFG_WIDTH'($urandom_range(7)));
		write_reg(REG_COLOR_SET, CFG_WIDTH'(modes.color_set));
		write_reg(REG_SEMIGRAPHICS_SELECT, CFG_WIDTH'(modes.semigraphics_select));
		write_reg(REG_SIX_BLOCK_SELECT, CFG_WIDTH'(modes.six_block_select));
		write_reg(REG_INVERT_TEXT, CFG_WIDTH'(modes.invert_text));
		write_reg(REG_SPARE_HI, CFG_WIDTH'($urandom_range(7)));
		cfg_we <= 1'b0;
		@(posedge clk);
		mode_regs = modes;
	endtask

	function automatic vbpd_cfg_t make_modes(input logic gs, input logic [2:0] gm,
			input logic cs, input logic sg, input logic sb, input logic inv);
		vbpd_cfg_t m;
		m.graphics_select = gs;
		m.graphics_mode = gm;
		m.color_set = cs;
		m.semigraphics_select = sg;
		m.six_block_select = sb;
		m.invert_text = inv;
		return m;
	endfunction

	// one bit per unit, doubled except in the densest mode
	task automatic test_resolution_graphics();
		load_modes(make_modes(1'b1, 3'd1, 1'b0, 1'b0, 1'b0, 1'b0));
		send_byte(8'd0, 8'hA5);
		load_modes(make_modes(1'b1, 3'd7, 1'b1, 1'b1, 1'b1, 1'b1));
		send_byte(8'd191, 8'h00);
		send_byte(8'd255, 8'hFF);
	endtask

	// two bits per unit from either palette half
	task automatic test_color_graphics();
		load_modes(make_modes(1'b1, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0));
		send_byte(8'd7, 8'h1B);
		load_modes(make_modes(1'b1, 3'd6, 1'b1, 1'b0, 1'b0, 1'b0));
		send_byte(8'd100, 8'hE4);
	endtask

	// font rows, blank rows, inversion, lines past the visible range
	task automatic test_text();
		load_modes(make_modes(1'b0, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0));
		send_byte(8'd3, 8'h00);
		send_byte(8'd9, 8'h3F);
		send_byte(8'd0, 8'hFF);
		load_modes(make_modes(1'b0, 3'd7, 1'b1, 1'b0, 1'b1, 1'b1));
		send_byte(8'd191, 8'h41);
		send_byte(8'd255, 8'h80);
		send_byte(8'd10, 8'h7F);
	endtask

	// 2x2 halves and 2x3 thirds
	task automatic test_semigraphics();
		load_modes(make_modes(1'b0, 3'd0, 1'b0, 1'b1, 1'b0, 1'b1));
		send_byte(8'd0, 8'hFF);
		send_byte(8'd6, 8'h8A);
		send_byte(8'd5, 8'h7C);
		load_modes(make_modes(1'b0, 3'd0, 1'b1, 1'b1, 1'b1, 1'b0));
		send_byte(8'd0, 8'hE1);
		send_byte(8'd4, 8'h5C);
		send_byte(8'd11, 8'h93);
		send_byte(8'd200, 8'h2F);
	endtask

	// random bytes under random and fixed modes, four phases of idling and stalls
	task automatic test_random_traffic();
		vbpd_cfg_t modes;
		logic [7:0] line_no;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 69; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 69; end
				default: begin send_idle_pct = 36; stall_pct = 36; end
			endcase
			for (int blk = 0; blk < 4; blk++) begin
				if (blk == 0)
					modes = (phase % 2 == 0) ? '0 : '1;
				else
					modes = vbpd_cfg_t'(8'($urandom_range(255)));
				load_modes(modes);
				repeat (20) begin
					if ($urandom_range(9) == 0)
						line_no = 8'($urandom_range(255, 192));
					else
						line_no = 8'($urandom_range(191));
					send_byte(line_no, 8'($urandom_range(255)));
				end
			end
		end
	endtask

	initial begin
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		mode_regs = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_resolution_graphics();
		test_color_graphics();
		test_text();
		test_semigraphics();
		test_random_traffic();
		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pixel_q.size() == 0)
			$display("tb_video_byte_pixel_decoder_unit: PASS");
		else
			$display("tb_video_byte_pixel_decoder_unit: FAIL");
		$finish;
	end

endmodule

[files.f]
+incdir+sv
sv/vbpd_pkg.sv
sv/vbpd_front.sv
sv/vbpd_queue.sv
sv/vbpd_back.sv
sv/video_byte_pixel_decoder_unit.sv
bench/tb_video_byte_pixel_decoder_unit.sv
